// ----- hw/rtl/cir_pkg.sv -----
// Shared types, constants and helpers for the contact impulse resolver.
// No dependencies; imported by every other module of the block.
`default_nettype none
package cir_pkg;

    localparam int NUM_W      = 54;
    localparam int DIV_W      = 32;
    localparam int FRONT_STG  = 4;
    localparam int BACK_STG   = 4;
    localparam int LATENCY    = FRONT_STG + NUM_W + BACK_STG;

    localparam logic [16:0] PERCENT_RST = 17'd52429;
    localparam logic [30:0] SLOP_RST    = 31'd655;
    localparam logic [15:0] THRESH_RST  = 16'd7;
    localparam logic [62:0] MAG_CAP     = 63'h4000_0000_0000_0000;

    typedef enum logic [1:0] {
        CFG_PERCENT = 2'd0,
        CFG_SLOP    = 2'd1,
        CFG_THRESH  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [16:0] percent;
        logic [30:0] slop;
        logic [15:0] thresh;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] vax;
        logic signed [31:0] vay;
        logic signed [31:0] vbx;
        logic signed [31:0] vby;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [30:0]        depth;
        logic [16:0]        ea;
        logic [16:0]        eb;
        logic [30:0]        ma;
        logic [30:0]        mb;
    } t_item;

    typedef struct packed {
        logic signed [31:0] vax;
        logic signed [31:0] vay;
        logic signed [31:0] vbx;
        logic signed [31:0] vby;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [30:0]        ma;
        logic [30:0]        mb;
        logic               resolved;
    } t_ctx;

    typedef struct packed {
        logic [NUM_W-1:0] num_j;
        logic [NUM_W-1:0] num_c;
        logic [DIV_W-1:0] msum;
    } t_div_req;

    typedef struct packed {
        logic [NUM_W-1:0] q_j;
        logic [NUM_W-1:0] q_c;
    } t_div_res;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [NUM_W-1:0] w;
    } t_dstep;

    typedef struct packed {
        logic signed [31:0] new_vel_a_x;
        logic signed [31:0] new_vel_a_y;
        logic signed [31:0] new_vel_b_x;
        logic signed [31:0] new_vel_b_y;
        logic signed [31:0] shift_a_x;
        logic signed [31:0] shift_a_y;
        logic signed [31:0] shift_b_x;
        logic signed [31:0] shift_b_y;
        logic               resolved;
    } t_result;

    // one restoring division step: shift in the next numerator bit
    function automatic t_dstep div_step(input logic [DIV_W-1:0] rem,
                                        input logic [NUM_W-1:0] w,
                                        input logic [DIV_W-1:0] d);
        logic [DIV_W:0] t;
        logic           ge;
        t_dstep         s;
        t = {rem, w[NUM_W-1]};
        ge = (t >= {1'b0, d});
        s.rem = ge ? DIV_W'(t - {1'b0, d}) : t[DIV_W-1:0];
        s.w = {w[NUM_W-2:0], ge};
        return s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        logic signed [31:0] r;
        if (v > 65'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -65'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cir_front.sv -----
// Front pipeline: relative velocity, normal speed, approach test and divider numerators.
// Depends on cir_pkg.
`default_nettype none
module cir_front import cir_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    input  t_item    i_item,
    output logic     o_valid,
    output t_ctx     o_ctx,
    output t_div_req o_req
);

    logic               r1_v, r2_v, r3_v, r4_v;
    t_ctx               r1_ctx, r2_ctx, r3_ctx, r4_ctx;
    logic signed [32:0] r1_rel_x, r1_rel_y;
    logic [17:0]        r1_e1, r2_e1, r3_e1;
    logic [30:0]        r1_exc;
    logic [31:0]        r1_msum, r2_msum, r3_msum;
    logic signed [48:0] r2_px, r2_py;
    logic [47:0]        r2_cexc, r3_cexc;
    logic signed [36:0] r3_close;
    t_div_req           r4_req;

    logic [16:0]        n_emin;
    logic signed [49:0] n_sum, n_adj;
    logic signed [36:0] n_close;
    logic               n_res;
    t_ctx               n_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_comb begin
        n_emin = (i_item.ea < i_item.eb) ? i_item.ea : i_item.eb;
        n_sum = 50'(r2_px) + 50'(r2_py);
        n_adj = n_sum + (n_sum[49] ? 50'sd16383 : 50'sd0);
        n_close = -37'($signed(n_adj[49:14]));
        n_res = (r2_msum != 32'd0) && (n_close >= $signed({21'd0, i_cfg.thresh}));
        n_ctx = r2_ctx;
        n_ctx.resolved = n_res;
    end

    always_ff @(posedge i_clk) begin
        r1_ctx.vax <= i_item.vax;
        r1_ctx.vay <= i_item.vay;
        r1_ctx.vbx <= i_item.vbx;
        r1_ctx.vby <= i_item.vby;
        r1_ctx.nx <= i_item.nx;
        r1_ctx.ny <= i_item.ny;
        r1_ctx.ma <= i_item.ma;
        r1_ctx.mb <= i_item.mb;
        r1_ctx.resolved <= 1'b0;
        r1_rel_x <= 33'(i_item.vbx) - 33'(i_item.vax);
        r1_rel_y <= 33'(i_item.vby) - 33'(i_item.vay);
        r1_e1 <= 18'(n_emin) + 18'd65536;
        r1_exc <= (i_item.depth > i_cfg.slop) ? (i_item.depth - i_cfg.slop) : 31'd0;
        r1_msum <= 32'(i_item.ma) + 32'(i_item.mb);

        r2_ctx <= r1_ctx;
        r2_px <= 49'(r1_rel_x) * 49'($signed(r1_ctx.nx));
        r2_py <= 49'(r1_rel_y) * 49'($signed(r1_ctx.ny));
        r2_cexc <= 48'(r1_exc) * 48'(i_cfg.percent);
        r2_e1 <= r1_e1;
        r2_msum <= r1_msum;

        r3_ctx <= n_ctx;
        r3_close <= n_close;
        r3_cexc <= r2_cexc;
        r3_e1 <= r2_e1;
        r3_msum <= r2_msum;

        r4_ctx <= r3_ctx;
        r4_req.num_j <= NUM_W'(r3_e1) * NUM_W'(r3_close[35:0]);
        r4_req.num_c <= NUM_W'(r3_cexc);
        r4_req.msum <= r3_msum;
    end

    assign o_valid = r4_v;
    assign o_ctx = r4_ctx;
    assign o_req = r4_req;

    a_res_msum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && r3_ctx.resolved) |-> (r3_msum != 32'd0))
        else $error("resolved contact with zero mass sum");

endmodule
`default_nettype wire

// ----- hw/rtl/cir_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, two numerators per divisor.
// Carries the contact context alongside; depends on cir_pkg.
`default_nettype none
module cir_div import cir_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_ctx     i_ctx,
    input  t_div_req i_req,
    output logic     o_valid,
    output t_ctx     o_ctx,
    output t_div_res o_res
);

    logic             r_v    [NUM_W];
    t_ctx             r_ctx  [NUM_W];
    logic [DIV_W-1:0] r_d    [NUM_W];
    logic [DIV_W-1:0] r_rj   [NUM_W];
    logic [DIV_W-1:0] r_rc   [NUM_W];
    logic [NUM_W-1:0] r_wj   [NUM_W];
    logic [NUM_W-1:0] r_wc   [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic             s_v;
        t_ctx             s_ctx;
        logic [DIV_W-1:0] s_d, s_rj, s_rc;
        logic [NUM_W-1:0] s_wj, s_wc;
        t_dstep           n_j, n_c;

        if (k == 0) begin : g_src
            assign s_v = i_valid;
            assign s_ctx = i_ctx;
            assign s_d = i_req.msum;
            assign s_rj = '0;
            assign s_rc = '0;
            assign s_wj = i_req.num_j;
            assign s_wc = i_req.num_c;
        end else begin : g_src
            assign s_v = r_v[k-1];
            assign s_ctx = r_ctx[k-1];
            assign s_d = r_d[k-1];
            assign s_rj = r_rj[k-1];
            assign s_rc = r_rc[k-1];
            assign s_wj = r_wj[k-1];
            assign s_wc = r_wc[k-1];
        end

        always_comb begin
            n_j = div_step(s_rj, s_wj, s_d);
            n_c = div_step(s_rc, s_wc, s_d);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_ctx[k] <= s_ctx;
            r_d[k] <= s_d;
            r_rj[k] <= n_j.rem;
            r_rc[k] <= n_c.rem;
            r_wj[k] <= n_j.w;
            r_wc[k] <= n_c.w;
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_ctx = r_ctx[NUM_W-1];
    assign o_res.q_j = r_wj[NUM_W-1];
    assign o_res.q_c = r_wc[NUM_W-1];

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NUM_W-1] && r_d[NUM_W-1] != '0) |->
        (r_rj[NUM_W-1] < r_d[NUM_W-1] && r_rc[NUM_W-1] < r_d[NUM_W-1]))
        else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

// ----- hw/rtl/cir_back.sv -----
// Back pipeline: impulse and correction along the normal, mass weighting, final saturation.
// Depends on cir_pkg.
`default_nettype none
module cir_back import cir_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_ctx     i_ctx,
    input  t_div_res i_res,
    output logic     o_valid,
    output t_result  o_res
);

    logic        r1_v, r2_v, r3_v, r_v;
    t_ctx        r1_ctx, r2_ctx, r3_ctx;
    logic [69:0] r1_p   [4];
    logic [54:0] r2_hi  [8];
    logic [62:0] r2_lo  [8];
    logic [62:0] r3_mag [8];
    t_result     r_out, n_out;

    logic [15:0] n_anx, n_any;
    logic signed [64:0] n_t [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r_v <= r3_v;
        end
    end

    // |n| as unsigned, the most negative code included
    always_comb begin
        n_anx = i_ctx.nx[15] ? (~i_ctx.nx + 16'd1) : i_ctx.nx;
        n_any = i_ctx.ny[15] ? (~i_ctx.ny + 16'd1) : i_ctx.ny;
    end

    always_ff @(posedge i_clk) begin
        r1_ctx <= i_ctx;
        r1_p[0] <= 70'(i_res.q_j) * 70'(n_anx);
        r1_p[1] <= 70'(i_res.q_j) * 70'(n_any);
        r1_p[2] <= 70'(i_res.q_c) * 70'(n_anx);
        r1_p[3] <= 70'(i_res.q_c) * 70'(n_any);
        r2_ctx <= r1_ctx;
        r3_ctx <= r2_ctx;
    end

    // terms: a_x a_y b_x b_y for the impulse, then the same for the shift
    for (genvar t = 0; t < 8; t++) begin : g_term
        localparam int SRC = (t / 4) * 2 + (t % 2);
        logic [55:0] s_mag;
        logic [30:0] s_w;
        logic [70:0] n_q;

        assign s_mag = r1_p[SRC][69:14];
        assign s_w = ((t % 4) < 2) ? r1_ctx.ma : r1_ctx.mb;
        assign n_q = {r2_hi[t], 16'd0} + 71'(r2_lo[t][62:16]);

        always_ff @(posedge i_clk) begin
            r2_hi[t] <= 55'(s_mag[55:32]) * 55'(s_w);
            r2_lo[t] <= 63'(s_mag[31:0]) * 63'(s_w);
            r3_mag[t] <= (n_q > 71'(MAG_CAP)) ? MAG_CAP : n_q[62:0];
        end

        assign n_t[t] = ((t % 2) == 0 ? r3_ctx.nx[15] : r3_ctx.ny[15]) ?
                        -$signed({2'b00, r3_mag[t]}) : $signed({2'b00, r3_mag[t]});
    end

    always_comb begin
        if (r3_ctx.resolved) begin
            n_out.new_vel_a_x = sat32(65'(r3_ctx.vax) - n_t[0]);
            n_out.new_vel_a_y = sat32(65'(r3_ctx.vay) - n_t[1]);
            n_out.new_vel_b_x = sat32(65'(r3_ctx.vbx) + n_t[2]);
            n_out.new_vel_b_y = sat32(65'(r3_ctx.vby) + n_t[3]);
            n_out.shift_a_x = sat32(-n_t[4]);
            n_out.shift_a_y = sat32(-n_t[5]);
            n_out.shift_b_x = sat32(n_t[6]);
            n_out.shift_b_y = sat32(n_t[7]);
            n_out.resolved = 1'b1;
        end else begin
            n_out.new_vel_a_x = r3_ctx.vax;
            n_out.new_vel_a_y = r3_ctx.vay;
            n_out.new_vel_b_x = r3_ctx.vbx;
            n_out.new_vel_b_y = r3_ctx.vby;
            n_out.shift_a_x = '0;
            n_out.shift_a_y = '0;
            n_out.shift_b_x = '0;
            n_out.shift_b_y = '0;
            n_out.resolved = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_v;
    assign o_res = r_out;

    a_skip_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && !r3_ctx.resolved) |=>
        (r_out.new_vel_a_x == $past(r3_ctx.vax) && r_out.new_vel_b_y == $past(r3_ctx.vby)))
        else $error("skipped contact changed velocity");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && !r3_ctx.resolved) |=>
        (r_out.shift_a_x == '0 && r_out.shift_a_y == '0 &&
         r_out.shift_b_x == '0 && r_out.shift_b_y == '0 && !r_out.resolved))
        else $error("skipped contact has nonzero shift");

    a_valid_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_v |-> ##3 r_v)
        else $error("result request lost in back pipeline");

endmodule
`default_nettype wire

// ----- hw/rtl/contact_impulse_resolver.sv -----
// Contact impulse resolver: one 2D contact per cycle, fully pipelined (4 front stages,
// 54 divider stages, 4 back stages); the 54-bit numerator of the restoring divider
// sets the depth. A request is taken whenever start is high (busy stays low); each
// result shows for one cycle with o_valid and cannot be held off. Configuration
// writes are always ready and must only happen while no contact is in flight.
// Depends on cir_pkg, cir_front, cir_div, cir_back.
`default_nettype none
module contact_impulse_resolver import cir_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic signed [31:0] i_vel_a_x,
    input  logic signed [31:0] i_vel_a_y,
    input  logic signed [31:0] i_vel_b_x,
    input  logic signed [31:0] i_vel_b_y,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic [30:0]        i_depth,
    input  logic [16:0]        i_restitution_a,
    input  logic [16:0]        i_restitution_b,
    input  logic [30:0]        i_mass_a,
    input  logic [30:0]        i_mass_b,
    output logic               o_valid,
    output logic signed [31:0] o_new_vel_a_x,
    output logic signed [31:0] o_new_vel_a_y,
    output logic signed [31:0] o_new_vel_b_x,
    output logic signed [31:0] o_new_vel_b_y,
    output logic signed [31:0] o_shift_a_x,
    output logic signed [31:0] o_shift_a_y,
    output logic signed [31:0] o_shift_b_x,
    output logic signed [31:0] o_shift_b_y,
    output logic               o_resolved
);

    t_cfg     r_cfg;
    t_item    s_item;
    logic     s_acc;
    logic     f_v, d_v;
    t_ctx     f_ctx, d_ctx;
    t_div_req f_req;
    t_div_res d_res;
    t_result  s_res;

    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign s_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.percent <= PERCENT_RST;
            r_cfg.slop <= SLOP_RST;
            r_cfg.thresh <= THRESH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PERCENT: r_cfg.percent <= i_cfg_data[16:0];
                CFG_SLOP:    r_cfg.slop <= i_cfg_data;
                CFG_THRESH:  r_cfg.thresh <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        s_item.vax = i_vel_a_x;
        s_item.vay = i_vel_a_y;
        s_item.vbx = i_vel_b_x;
        s_item.vby = i_vel_b_y;
        s_item.nx = i_normal_x;
        s_item.ny = i_normal_y;
        s_item.depth = i_depth;
        s_item.ea = i_restitution_a;
        s_item.eb = i_restitution_b;
        s_item.ma = i_mass_a;
        s_item.mb = i_mass_b;
    end

    cir_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_acc),
        .i_item  (s_item),
        .o_valid (f_v),
        .o_ctx   (f_ctx),
        .o_req   (f_req)
    );

    cir_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_v),
        .i_ctx   (f_ctx),
        .i_req   (f_req),
        .o_valid (d_v),
        .o_ctx   (d_ctx),
        .o_res   (d_res)
    );

    cir_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_v),
        .i_ctx   (d_ctx),
        .i_res   (d_res),
        .o_valid (o_valid),
        .o_res   (s_res)
    );

    assign o_new_vel_a_x = s_res.new_vel_a_x;
    assign o_new_vel_a_y = s_res.new_vel_a_y;
    assign o_new_vel_b_x = s_res.new_vel_b_x;
    assign o_new_vel_b_y = s_res.new_vel_b_y;
    assign o_shift_a_x = s_res.shift_a_x;
    assign o_shift_a_y = s_res.shift_a_y;
    assign o_shift_b_x = s_res.shift_b_x;
    assign o_shift_b_y = s_res.shift_b_y;
    assign o_resolved = s_res.resolved;

endmodule
`default_nettype wire
